// File: src/msd_pkg.sv
// Shared types, codes and the power-of-ten table for the middle-square generator.
`timescale 1ns / 1ps
package msd_pkg;

   localparam int unsigned SeedW   = 32;
   localparam int unsigned SqW     = 64;
   localparam int unsigned DigW    = 5;
   localparam logic [DigW-1:0] DigitsMax = 5'd19;

   // divider operand selection
   localparam logic [1:0] DIV_DROP  = 2'd0;
   localparam logic [1:0] DIV_KEEP  = 2'd1;
   localparam logic [1:0] DIV_RANGE = 2'd2;

   // result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_ORDER = 2'd1;
   localparam logic [1:0] STAT_ZERO  = 2'd2;

   typedef struct packed {
      logic       load_seed;
      logic       capture;
      logic       square;
      logic       count;
      logic       div_start;
      logic [1:0] div_sel;
      logic       commit;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic min_gt_max;
      logic range_zero;
      logic cnt_done;
      logic div_busy;
      logic out_free;
   } sts_type;

   function automatic logic [SqW-1:0] pow10(input logic [DigW-1:0] e);
      logic [SqW-1:0] r;
      unique case (e)
         5'd0:    r = 64'd1;
         5'd1:    r = 64'd10;
         5'd2:    r = 64'd100;
         5'd3:    r = 64'd1000;
         5'd4:    r = 64'd10000;
         5'd5:    r = 64'd100000;
         5'd6:    r = 64'd1000000;
         5'd7:    r = 64'd10000000;
         5'd8:    r = 64'd100000000;
         5'd9:    r = 64'd1000000000;
         5'd10:   r = 64'd10000000000;
         5'd11:   r = 64'd100000000000;
         5'd12:   r = 64'd1000000000000;
         5'd13:   r = 64'd10000000000000;
         5'd14:   r = 64'd100000000000000;
         5'd15:   r = 64'd1000000000000000;
         5'd16:   r = 64'd10000000000000000;
         5'd17:   r = 64'd100000000000000000;
         5'd18:   r = 64'd1000000000000000000;
         5'd19:   r = 64'd10000000000000000000;
         default: r = '1;
      endcase
      return r;
   endfunction

endpackage

// File: src/middle_square_decimal_prng_top.sv
// Decimal middle-square generator: a request loads the seed or draws a number.
// Draw: capture, check (min > max ends here), square, digit count, then the shared
// serial divider: drop digits, keep digits, range mod (skipped for a zero range).
// One item in flight; the result register frees the output side on its own.
// Synchronous active-high reset clears the seed to zero and empties the output.
`timescale 1ns / 1ps
module middle_square_decimal_prng_top
   import msd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_action,
   input  logic [SeedW-1:0] req_seed_value,
   input  logic [SeedW-1:0] req_range_min,
   input  logic [SeedW-1:0] req_range_max,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [SeedW-1:0] rsp_middle_value,
   output logic [SeedW-1:0] rsp_ranged_value,
   output logic [1:0]       rsp_status
);

   cmd_type cmd;
   sts_type sts;

   msd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .sts        (sts),
      .cmd        (cmd),
      .req_stall  (req_stall)
   );

   msd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_seed_value   (req_seed_value),
      .req_range_min    (req_range_min),
      .req_range_max    (req_range_max),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_middle_value (rsp_middle_value),
      .rsp_ranged_value (rsp_ranged_value),
      .rsp_status       (rsp_status)
   );

endmodule

// File: src/msd_div.sv
// Serial restoring divider, one quotient bit per cycle, 64 or 32 steps.
`timescale 1ns / 1ps
module msd_div
   import msd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           half,
   input  logic [SqW-1:0] dvd_i,
   input  logic [SqW-1:0] dvs_i,
   output logic           busy,
   output logic [SqW-1:0] quot,
   output logic [SqW-1:0] rem
);

   logic           busy_ff, busy_in;
   logic [6:0]     cnt_ff, cnt_in;
   logic [SqW:0]   rem_ff, rem_in;
   logic [SqW-1:0] dvd_ff, dvd_in;
   logic [SqW-1:0] dvs_ff, dvs_in;
   logic [SqW:0]   trial;
   logic           ge;

   assign trial = {rem_ff[SqW-1:0], dvd_ff[SqW-1]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = half ? 7'd32 : 7'd64;
         rem_in  = '0;
         // short mode: dividend bits sit at the top so they shift in first
         dvd_in  = half ? {dvd_i[SeedW-1:0], {SeedW{1'b0}}} : dvd_i;
         dvs_in  = dvs_i;
      end else if (busy_ff) begin
         rem_in = ge ? (trial - {1'b0, dvs_ff}) : trial;
         dvd_in = {dvd_ff[SqW-2:0], ge};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign busy = busy_ff;
   assign quot = dvd_ff;
   assign rem  = rem_ff[SqW-1:0];

endmodule

// File: src/msd_dp.sv
// Datapath: seed, square, digit counters, shared divider and result register.
`timescale 1ns / 1ps
module msd_dp
   import msd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic [SeedW-1:0] req_seed_value,
   input  logic [SeedW-1:0] req_range_min,
   input  logic [SeedW-1:0] req_range_max,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic [SeedW-1:0] rsp_middle_value,
   output logic [SeedW-1:0] rsp_ranged_value,
   output logic [1:0]       rsp_status
);

   logic [SeedW-1:0] seed_ff, lo_ff, range_ff;
   logic             gt_ff, zero_ff;
   logic [SqW-1:0]   sq_ff;
   logic [DigW-1:0]  k_ff, d_ff, sqd_ff;
   logic [DigW-1:0]  half_sq, half_d, drop;
   logic             rsp_valid_ff;
   logic [SeedW-1:0] mid_ff, ranged_ff;
   logic [1:0]       status_ff;

   logic             div_half, div_busy;
   logic [SqW-1:0]   div_dvd, div_dvs, div_quot, div_rem;

   assign half_sq = sqd_ff >> 1;
   assign half_d  = d_ff >> 1;
   assign drop    = (half_sq > half_d) ? (half_sq - half_d) : '0;

   always_comb begin
      div_half = 1'b0;
      case (cmd.div_sel)
         DIV_DROP: begin
            div_dvd = sq_ff;
            div_dvs = pow10(drop);
         end
         DIV_KEEP: begin
            div_dvd = div_quot;
            div_dvs = pow10(d_ff);
         end
         default: begin
            div_dvd  = {{(SqW-SeedW){1'b0}}, seed_ff};
            div_dvs  = {{(SqW-SeedW){1'b0}}, range_ff};
            div_half = 1'b1;
         end
      endcase
   end

   msd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .half  (div_half),
      .dvd_i (div_dvd),
      .dvs_i (div_dvs),
      .busy  (div_busy),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_seed) begin
            seed_ff <= req_seed_value;
         end else if (cmd.commit) begin
            seed_ff <= div_rem[SeedW-1:0];
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         lo_ff    <= req_range_min;
         range_ff <= req_range_max - req_range_min;
         gt_ff    <= req_range_min > req_range_max;
         zero_ff  <= req_range_min == req_range_max;
      end
      if (cmd.square) begin
         sq_ff  <= {{SeedW{1'b0}}, seed_ff} * {{SeedW{1'b0}}, seed_ff};
         k_ff   <= 5'd1;
         d_ff   <= 5'd1;
         sqd_ff <= 5'd1;
      end else if (cmd.count) begin
         k_ff <= k_ff + 5'd1;
         if (sq_ff >= pow10(k_ff)) begin
            sqd_ff <= sqd_ff + 5'd1;
         end
         if ({{(SqW-SeedW){1'b0}}, seed_ff} >= pow10(k_ff)) begin
            d_ff <= d_ff + 5'd1;
         end
      end
      if (cmd.out_load) begin
         if (gt_ff) begin
            mid_ff    <= '0;
            ranged_ff <= 32'd1;
            status_ff <= STAT_ORDER;
         end else if (zero_ff) begin
            mid_ff    <= seed_ff;
            ranged_ff <= 32'd1;
            status_ff <= STAT_ZERO;
         end else begin
            mid_ff    <= seed_ff;
            ranged_ff <= lo_ff + div_rem[SeedW-1:0] + 32'd1;
            status_ff <= STAT_OK;
         end
      end
   end

   assign sts.min_gt_max = gt_ff;
   assign sts.range_zero = zero_ff;
   assign sts.cnt_done   = k_ff == DigitsMax;
   assign sts.div_busy   = div_busy;
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_middle_value = mid_ff;
   assign rsp_ranged_value = ranged_ff;
   assign rsp_status       = status_ff;

endmodule

// File: src/msd_ctrl.sv
// Controller state machine sequencing square, digit count and the three divisions.
`timescale 1ns / 1ps
module msd_ctrl
   import msd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_action,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    req_stall
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CHECK = 4'd1;
   localparam logic [3:0] ST_SQR   = 4'd2;
   localparam logic [3:0] ST_CNT   = 4'd3;
   localparam logic [3:0] ST_STA   = 4'd4;
   localparam logic [3:0] ST_WTA   = 4'd5;
   localparam logic [3:0] ST_STB   = 4'd6;
   localparam logic [3:0] ST_WTB   = 4'd7;
   localparam logic [3:0] ST_STC   = 4'd8;
   localparam logic [3:0] ST_WTC   = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = DIV_DROP;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_action) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_CHECK;
               end else begin
                  cmd.load_seed = 1'b1;
               end
            end
         end
         ST_CHECK: state_in = sts.min_gt_max ? ST_DONE : ST_SQR;
         ST_SQR: begin
            cmd.square = 1'b1;
            state_in   = ST_CNT;
         end
         ST_CNT: begin
            cmd.count = 1'b1;
            if (sts.cnt_done) begin
               state_in = ST_STA;
            end
         end
         ST_STA: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WTA;
         end
         ST_WTA: if (!sts.div_busy) state_in = ST_STB;
         ST_STB: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_KEEP;
            state_in      = ST_WTB;
         end
         ST_WTB: begin
            if (!sts.div_busy) begin
               cmd.commit = 1'b1;
               state_in   = sts.range_zero ? ST_DONE : ST_STC;
            end
         end
         ST_STC: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_RANGE;
            state_in      = ST_WTC;
         end
         ST_WTC: if (!sts.div_busy) state_in = ST_DONE;
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

endmodule

// File: src/msd_checker.sv
// Port-level checks for the middle-square generator, bound to the top level.
`timescale 1ns / 1ps
module msd_port_checker
   import msd_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [SeedW-1:0] rsp_middle_value,
   input logic [SeedW-1:0] rsp_ranged_value,
   input logic [1:0]       rsp_status
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_middle_value)
         && $stable(rsp_ranged_value) && $stable(rsp_status))
      else $error("stalled result changed");

   a_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STAT_OK || rsp_status == STAT_ORDER
         || rsp_status == STAT_ZERO)
      else $error("bad status code");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_ORDER |-> rsp_middle_value == 32'd0
         && rsp_ranged_value == 32'd1)
      else $error("order error result wrong");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_ZERO |-> rsp_ranged_value == 32'd1)
      else $error("zero range result wrong");

endmodule

bind middle_square_decimal_prng_top msd_port_checker u_msd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_middle_value (rsp_middle_value),
   .rsp_ranged_value (rsp_ranged_value),
   .rsp_status       (rsp_status)
);

// File: tb/msd_checker.sv
// Checker for the middle-square generator: predicts each draw and compares the results.
`timescale 1ns / 1ps
module msd_checker
   import msd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic             req_action,
   input  logic [SeedW-1:0] req_seed_value,
   input  logic [SeedW-1:0] req_range_min,
   input  logic [SeedW-1:0] req_range_max,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [SeedW-1:0] rsp_middle_value,
   input  logic [SeedW-1:0] rsp_ranged_value,
   input  logic [1:0]       rsp_status,
   output int               errors,
   output int               pending
);

   typedef struct packed {
      logic [SeedW-1:0] middle;
      logic [SeedW-1:0] ranged;
      logic [1:0]       status;
   } draw_result_type;

   draw_result_type draws_due[$];
   logic [SeedW-1:0] seed_model;

   function automatic int dec_count(input logic [SqW-1:0] v);
      int n;
      n = 0;
      do begin
         v = v / 64'd10;
         n++;
      end while (v != 0);
      return n;
   endfunction

   function automatic logic [SqW-1:0] ten_to(input int e);
      logic [SqW-1:0] r;
      r = 64'd1;
      for (int i = 0; i < e; i++) r = r * 64'd10;
      return r;
   endfunction

   assign pending = draws_due.size();

   always @(posedge clock) begin
      draw_result_type exp_r, got;
      logic [SqW-1:0] sq;
      logic [SeedW-1:0] span;
      int d, sqd, drop;
      if (reset) begin
         seed_model <= '0;
         draws_due.delete();
         errors <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (!req_action) begin
               seed_model <= req_seed_value;
            end else if (req_range_min > req_range_max) begin
               exp_r = '{middle: '0, ranged: 32'd1, status: STAT_ORDER};
               draws_due.push_back(exp_r);
            end else begin
               span = req_range_max - req_range_min;
               d = dec_count({32'd0, seed_model});
               sq = {32'd0, seed_model} * {32'd0, seed_model};
               sqd = dec_count(sq);
               drop = (sqd / 2 > d / 2) ? sqd / 2 - d / 2 : 0;
               exp_r.middle = SeedW'((sq / ten_to(drop)) % ten_to(d));
               seed_model <= exp_r.middle;
               if (span == 0) begin
                  exp_r.ranged = 32'd1;
                  exp_r.status = STAT_ZERO;
               end else begin
                  exp_r.ranged = req_range_min + (exp_r.middle % span) + 32'd1;
                  exp_r.status = STAT_OK;
               end
               draws_due.push_back(exp_r);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{middle: rsp_middle_value, ranged: rsp_ranged_value, status: rsp_status};
            if (draws_due.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected result transfer mid=%h rng=%h st=%0d",
                           $realtime, got.middle, got.ranged, got.status);
               errors <= errors + 1;
            end else begin
               exp_r = draws_due.pop_front();
               if (got !== exp_r) begin
                  if (errors < 10)
                     $display("%0t: mismatch exp mid=%h rng=%h st=%0d got mid=%h rng=%h st=%0d",
                              $realtime, exp_r.middle, exp_r.ranged, exp_r.status,
                              got.middle, got.ranged, got.status);
                  errors <= errors + 1;
               end
            end
         end
      end
   end

endmodule

// File: tb/tb_middle_square_decimal_prng_top.sv
// Testbench top: stimulus, result back-pressure and the final verdict.
`timescale 1ns / 1ps
module tb_middle_square_decimal_prng_top;
   import msd_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_action = 1'b0;
   logic [SeedW-1:0] req_seed_value = '0;
   logic [SeedW-1:0] req_range_min = '0;
   logic [SeedW-1:0] req_range_max = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [SeedW-1:0] rsp_middle_value;
   logic [SeedW-1:0] rsp_ranged_value;
   logic [1:0]       rsp_status;
   int               errors;
   int               pending;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_DRAW = 1'b1;

   always #4 clock = ~clock;

   middle_square_decimal_prng_top u_top (.*);

   msd_checker u_checker (.*);

   task automatic send(input logic act, input logic [31:0] sv,
                       input logic [31:0] lo, input logic [31:0] hi);
      int gap;
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_action     <= act;
      req_seed_value <= sv;
      req_range_min  <= lo;
      req_range_max  <= hi;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic random_draw();
      logic [31:0] a, b;
      int kind;
      kind = $urandom_range(0, 9);
      a = $urandom >> $urandom_range(0, 31);
      b = $urandom >> $urandom_range(0, 31);
      if (kind == 0) send(ACT_DRAW, $urandom, a, a);
      else if (kind == 1) send(ACT_DRAW, $urandom, (a > b) ? a : b + 1, (a > b) ? b : a);
      else send(ACT_DRAW, $urandom, (a < b) ? a : b, (a < b) ? b : a);
   endtask

   // receiver: random stalls, bursts without stalls and one long hold-off
   initial begin
      int k, taken;
      bit burst;
      taken = 0;
      burst = 0;
      wait (!reset);
      forever begin
         if (taken % 50 == 0) burst = ($urandom_range(0, 3) == 0);
         k = burst ? 0 : $urandom_range(0, 16);
         if (taken == 300) k = 3000;
         if (k > 0) begin
            rsp_stall <= 1'b1;
            repeat (k) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         taken++;
      end
   end

   initial begin
      #25ms;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      bit paused;
      paused = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // zero seed after reset, ordering and zero-range cases, extreme bounds
      send(ACT_DRAW, '0, 32'd0, 32'd10);
      send(ACT_DRAW, '0, 32'd5, 32'd4);
      send(ACT_DRAW, '0, 32'hFFFF_FFFF, 32'd0);
      send(ACT_LOAD, 32'hFFFF_FFFF, '0, '0);
      send(ACT_DRAW, '1, 32'd0, 32'hFFFF_FFFF);
      send(ACT_LOAD, 32'd4294967295, '1, '1);
      send(ACT_DRAW, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(ACT_LOAD, 32'd3999999999, '0, '0);
      send(ACT_DRAW, '0, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
      send(ACT_LOAD, 32'd7, '0, '0);
      send(ACT_DRAW, '0, 32'd0, 32'd0);
      send(ACT_DRAW, '0, 32'd1, 32'd2);
      send(ACT_LOAD, 32'd1234567890, '0, '0);
      send(ACT_DRAW, '0, 32'd100, 32'd1000);
      send(ACT_DRAW, '0, 32'd0, 32'd1);
      send(ACT_LOAD, 32'd0, '0, '0);
      send(ACT_DRAW, '0, 32'd3, 32'd9);
      send(ACT_LOAD, 32'd9999, '0, '0);
      send(ACT_DRAW, '1, 32'h8000_0000, 32'hFFFF_FFFE);
      // random: a load, then a run of draws from that seed
      for (int n = 0; n < 1280; ) begin
         send(ACT_LOAD, $urandom >> $urandom_range(0, 31), $urandom, $urandom);
         n++;
         for (int j = $urandom_range(1, 12); j > 0; j--) begin
            random_draw();
            n++;
            if (n >= 700 && !paused) begin
               paused = 1'b1;
               req_valid <= 1'b0;
               // let the checker book the last transfer before testing the count
               @(posedge clock);
               wait (pending == 0);
               @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (300) @(posedge clock);
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
